@@ design/assert_macros.svh @@
// Concurrent assertion helpers for the RTL of this project.
// Arguments hold no commas; compose larger conditions in named signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/adll_pkg.sv @@
`timescale 1ns / 1ps
package adll_pkg;

   // Write enables for the separate fields of one link memory entry.
   typedef struct packed {
      logic linked;
      logic next;
      logic prev;
   } link_we_type;

   // Operation carried by an input item.
   typedef enum logic [1:0] {
      OP_PUSH_FRONT    = 2'd0,
      OP_INSERT_BEFORE = 2'd1,
      OP_INSERT_AFTER  = 2'd2,
      OP_UNLINK        = 2'd3
   } op_type;

   // Status reported with every result item.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_FREE    = 2'd1,
      ST_NOT_LINKED = 2'd2
   } status_type;

endpackage

@@ design/adll_pay_mem.sv @@
`timescale 1ns / 1ps
// Node payload store: one write port, one registered read port.
module adll_pay_mem #(
   parameter int NODES        = 64,
   parameter int PAYLOAD_BITS = 32,
   localparam int IDX_W       = $clog2(NODES)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [PAYLOAD_BITS-1:0] wr_data,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic [PAYLOAD_BITS-1:0] rd_data_ff
);

   logic [PAYLOAD_BITS-1:0] store_ff [NODES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule

@@ design/adll_link_mem.sv @@
`timescale 1ns / 1ps
// Link store: linked flag, next and prev per node. One write address per cycle
// with a write enable per field; two registered read ports.
module adll_link_mem #(
   parameter int NODES   = 64,
   localparam int IDX_W  = $clog2(NODES),
   localparam int LINK_W = IDX_W + 1
) (
   input  logic                  clock,
   input  adll_pkg::link_we_type wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic                  wr_linked,
   input  logic [LINK_W-1:0]     wr_next,
   input  logic [LINK_W-1:0]     wr_prev,
   input  logic [IDX_W-1:0]      rd_a_addr,
   output logic                  rd_a_linked_ff,
   output logic [LINK_W-1:0]     rd_a_next_ff,
   output logic [LINK_W-1:0]     rd_a_prev_ff,
   input  logic [IDX_W-1:0]      rd_b_addr,
   output logic [LINK_W-1:0]     rd_b_next_ff
);

   logic              linked_ff [NODES];
   logic [LINK_W-1:0] next_ff   [NODES];
   logic [LINK_W-1:0] prev_ff   [NODES];

   always_ff @(posedge clock) begin
      if (wr_en.linked) begin
         linked_ff[wr_addr] <= wr_linked;
      end
      if (wr_en.next) begin
         next_ff[wr_addr] <= wr_next;
      end
      if (wr_en.prev) begin
         prev_ff[wr_addr] <= wr_prev;
      end
      rd_a_linked_ff <= linked_ff[rd_a_addr];
      rd_a_next_ff   <= next_ff[rd_a_addr];
      rd_a_prev_ff   <= prev_ff[rd_a_addr];
      rd_b_next_ff   <= next_ff[rd_b_addr];
   end

endmodule

@@ design/array_doubly_linked_list.sv @@
`timescale 1ns / 1ps
// An item passes EXAM, NBR_A and NBR_B (EXAM and FIN on an error); its result is
// then registered at the output. No new item is taken until IDLE; the single write
// port of the link memory sets this, as an operation rewrites up to three entries.
// Reset: control registers clear at once; the memories keep no reset and need no
// clearing pass, as a counter of nodes ever handed out marks the untouched ones.
module array_doubly_linked_list #(
   parameter int NODES        = 64,
   parameter int PAYLOAD_BITS = 32,
   localparam int IDX_W       = $clog2(NODES),
   localparam int LINK_W      = IDX_W + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [IDX_W-1:0]         req_node_index,
   input  logic [PAYLOAD_BITS-1:0]  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [LINK_W-1:0] rsp_result_index,
   output logic [PAYLOAD_BITS-1:0]  rsp_result_payload,
   output logic [1:0]               rsp_status,
   output logic signed [LINK_W-1:0] rsp_front_now,
   output logic signed [LINK_W-1:0] rsp_back_now
);

`include "assert_macros.svh"

   // A link value is a node index with one extra top bit; all ones means no node.
   localparam logic [LINK_W-1:0] NIL     = '1;
   localparam logic [LINK_W-1:0] NODES_L = LINK_W'(NODES);

   // EXAM decides the operation and writes the node itself; NBR_A and NBR_B patch
   // the next field of the left neighbour and the prev field of the right one.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXAM,
      S_NBR_A,
      S_NBR_B,
      S_FIN
   } state_type;

   state_type                 state_ff, state_in;
   adll_pkg::op_type          op_ff, op_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [PAYLOAD_BITS-1:0]   pay_ff, pay_in;
   logic [LINK_W-1:0]         front_ff, front_in;
   logic [LINK_W-1:0]         back_ff, back_in;
   // Freed nodes are chained through their next field, most recently freed first.
   logic [LINK_W-1:0]         free_top_ff, free_top_in;
   // Nodes that have never been handed out are taken in ascending order; this
   // counts how many have gone, so any node at or above it is known to be free.
   logic [LINK_W-1:0]         virgin_ff, virgin_in;
   logic [LINK_W-1:0]         nbr_a_ff, nbr_a_in;
   logic [LINK_W-1:0]         nbr_a_val_ff, nbr_a_val_in;
   logic [LINK_W-1:0]         nbr_b_ff, nbr_b_in;
   logic [LINK_W-1:0]         nbr_b_val_ff, nbr_b_val_in;
   logic [LINK_W-1:0]         res_index_ff, res_index_in;
   logic [PAYLOAD_BITS-1:0]   res_payload_ff, res_payload_in;
   adll_pkg::status_type      res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LINK_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [PAYLOAD_BITS-1:0]   rsp_payload_ff, rsp_payload_in;
   adll_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [LINK_W-1:0]         rsp_front_ff, rsp_front_in;
   logic [LINK_W-1:0]         rsp_back_ff, rsp_back_in;

   adll_pkg::link_we_type     link_we;
   logic [IDX_W-1:0]          link_wr_addr;
   logic                      link_wr_linked;
   logic [LINK_W-1:0]         link_wr_next;
   logic [LINK_W-1:0]         link_wr_prev;
   logic                      link_a_linked;
   logic [LINK_W-1:0]         link_a_next;
   logic [LINK_W-1:0]         link_a_prev;
   logic [LINK_W-1:0]         link_b_next;
   logic                      pay_we;
   logic [IDX_W-1:0]          pay_wr_addr;
   logic [PAYLOAD_BITS-1:0]   pay_rd;

   logic                      accept;
   logic                      out_free;
   logic                      load_rsp;
   logic [LINK_W-1:0]         idx_ext;
   logic                      is_linked;
   logic                      free_empty;
   logic [IDX_W-1:0]          new_node;
   logic [LINK_W-1:0]         new_ext;
   logic                      is_push;
   logic [LINK_W-1:0]         p_new;
   logic [LINK_W-1:0]         n_new;
   logic                      free_top_seen;
   logic                      list_empty;
   logic                      ends_agree;

   // Both memories are read at the address of the incoming item in the cycle it
   // is taken, and the link memory also at the head of the freed chain. No write
   // happens in the idle state, so these reads always see the finished state of
   // the item before.
   adll_link_mem #(
      .NODES (NODES)
   ) u_link_mem (
      .clock          (clock),
      .wr_en          (link_we),
      .wr_addr        (link_wr_addr),
      .wr_linked      (link_wr_linked),
      .wr_next        (link_wr_next),
      .wr_prev        (link_wr_prev),
      .rd_a_addr      (req_node_index),
      .rd_a_linked_ff (link_a_linked),
      .rd_a_next_ff   (link_a_next),
      .rd_a_prev_ff   (link_a_prev),
      .rd_b_addr      (free_top_ff[IDX_W-1:0]),
      .rd_b_next_ff   (link_b_next)
   );

   adll_pay_mem #(
      .NODES        (NODES),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_pay_mem (
      .clock      (clock),
      .wr_en      (pay_we),
      .wr_addr    (pay_wr_addr),
      .wr_data    (pay_ff),
      .rd_addr    (req_node_index),
      .rd_data_ff (pay_rd)
   );

   assign req_stall          = (state_ff != S_IDLE);
   assign accept             = req_valid && (state_ff == S_IDLE);
   assign out_free           = !rsp_valid_ff || !rsp_stall;
   assign load_rsp           = ((state_ff == S_NBR_B) || (state_ff == S_FIN)) && out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_index   = rsp_index_ff;
   assign rsp_result_payload = rsp_payload_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_front_now      = rsp_front_ff;
   assign rsp_back_now       = rsp_back_ff;

   // Decode of the item under examination. A node counts as linked only if it
   // is in range, has been handed out at some time, and carries its flag; the
   // flag of a node never handed out is never trusted, since that entry was
   // never written.
   always_comb begin
      idx_ext       = {1'b0, idx_ff};
      is_linked     = (idx_ext < NODES_L) && (idx_ext < virgin_ff) && link_a_linked;
      free_empty    = free_top_ff[LINK_W-1] && (virgin_ff == NODES_L);
      new_node      = free_top_ff[LINK_W-1] ? virgin_ff[IDX_W-1:0] : free_top_ff[IDX_W-1:0];
      new_ext       = {1'b0, new_node};
      // Inserting before the front node is the same as pushing at the front.
      is_push       = (op_ff == adll_pkg::OP_PUSH_FRONT) ||
                      ((op_ff == adll_pkg::OP_INSERT_BEFORE) && (front_ff == idx_ext));
      if (is_push) begin
         p_new = NIL;
         n_new = front_ff;
      end else if (op_ff == adll_pkg::OP_INSERT_BEFORE) begin
         p_new = link_a_prev;
         n_new = idx_ext;
      end else begin
         p_new = idx_ext;
         n_new = link_a_next;
      end
      // An empty freed chain, or a head that has been handed out before.
      free_top_seen = free_top_ff[LINK_W-1] ||
                      ({1'b0, free_top_ff[IDX_W-1:0]} < virgin_ff);
      list_empty    = front_ff[LINK_W-1];
      ends_agree    = (front_ff[LINK_W-1] == back_ff[LINK_W-1]);
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      pay_in         = pay_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      free_top_in    = free_top_ff;
      virgin_in      = virgin_ff;
      nbr_a_in       = nbr_a_ff;
      nbr_a_val_in   = nbr_a_val_ff;
      nbr_b_in       = nbr_b_ff;
      nbr_b_val_in   = nbr_b_val_ff;
      res_index_in   = res_index_ff;
      res_payload_in = res_payload_ff;
      res_status_in  = res_status_ff;

      link_we        = '0;
      link_wr_addr   = idx_ff;
      link_wr_linked = 1'b0;
      link_wr_next   = NIL;
      link_wr_prev   = NIL;
      pay_we         = 1'b0;
      pay_wr_addr    = new_node;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = adll_pkg::op_type'(req_op);
               idx_in   = req_node_index;
               pay_in   = req_payload;
               state_in = S_EXAM;
            end
         end

         S_EXAM: begin
            res_index_in   = NIL;
            res_payload_in = '0;
            if ((op_ff != adll_pkg::OP_PUSH_FRONT) && !is_linked) begin
               // The named node is not in the list: nothing changes.
               res_status_in = adll_pkg::ST_NOT_LINKED;
               state_in      = S_FIN;
            end else if (op_ff == adll_pkg::OP_UNLINK) begin
               // Clear the flag and chain the node onto the freed list.
               link_we.linked = 1'b1;
               link_we.next   = 1'b1;
               link_wr_addr   = idx_ff;
               link_wr_linked = 1'b0;
               link_wr_next   = free_top_ff;
               free_top_in    = idx_ext;
               // The front node has no predecessor and the back node no
               // successor, so the neighbour patches below cover every case,
               // including the only node, where front and back both clear.
               if (front_ff == idx_ext) begin
                  front_in = link_a_next;
               end
               if (back_ff == idx_ext) begin
                  back_in = link_a_prev;
               end
               nbr_a_in       = link_a_prev;
               nbr_a_val_in   = link_a_next;
               nbr_b_in       = link_a_next;
               nbr_b_val_in   = link_a_prev;
               res_index_in   = idx_ext;
               res_payload_in = pay_rd;
               res_status_in  = adll_pkg::ST_OK;
               state_in       = S_NBR_A;
            end else if (free_empty) begin
               res_status_in = adll_pkg::ST_NO_FREE;
               state_in      = S_FIN;
            end else begin
               // Take a node, freed ones first, and write it whole.
               link_we        = '1;
               link_wr_addr   = new_node;
               link_wr_linked = 1'b1;
               link_wr_next   = n_new;
               link_wr_prev   = p_new;
               pay_we         = 1'b1;
               if (free_top_ff[LINK_W-1]) begin
                  virgin_in = virgin_ff + LINK_W'(1);
               end else begin
                  free_top_in = link_b_next;
               end
               if (p_new[LINK_W-1]) begin
                  front_in = new_ext;
               end
               if (n_new[LINK_W-1]) begin
                  back_in = new_ext;
               end
               nbr_a_in      = p_new;
               nbr_a_val_in  = new_ext;
               nbr_b_in      = n_new;
               nbr_b_val_in  = new_ext;
               res_index_in  = new_ext;
               res_status_in = adll_pkg::ST_OK;
               state_in      = S_NBR_A;
            end
         end

         S_NBR_A: begin
            if (!nbr_a_ff[LINK_W-1]) begin
               link_we.next = 1'b1;
               link_wr_addr = nbr_a_ff[IDX_W-1:0];
               link_wr_next = nbr_a_val_ff;
            end
            state_in = S_NBR_B;
         end

         S_NBR_B: begin
            if (!nbr_b_ff[LINK_W-1]) begin
               link_we.prev = 1'b1;
               link_wr_addr = nbr_b_ff[IDX_W-1:0];
               link_wr_prev = nbr_b_val_ff;
            end
            state_in = load_rsp ? S_IDLE : S_FIN;
         end

         S_FIN: begin
            // Waiting only for the output register to drain.
            state_in = load_rsp ? S_IDLE : S_FIN;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The output register lets the result wait while the next item is taken.
   always_comb begin
      rsp_valid_in   = load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_index_in   = rsp_index_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_back_in    = rsp_back_ff;
      if (load_rsp) begin
         rsp_index_in   = res_index_ff;
         rsp_payload_in = res_payload_ff;
         rsp_status_in  = res_status_ff;
         rsp_front_in   = front_ff;
         rsp_back_in    = back_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= NIL;
         back_ff      <= NIL;
         free_top_ff  <= NIL;
         virgin_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         free_top_ff  <= free_top_in;
         virgin_ff    <= virgin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      idx_ff         <= idx_in;
      pay_ff         <= pay_in;
      nbr_a_ff       <= nbr_a_in;
      nbr_a_val_ff   <= nbr_a_val_in;
      nbr_b_ff       <= nbr_b_in;
      nbr_b_val_ff   <= nbr_b_val_in;
      res_index_ff   <= res_index_in;
      res_payload_ff <= res_payload_in;
      res_status_ff  <= res_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_back_ff    <= rsp_back_in;
   end

   `ASSERT_IMPLY(a_ends_agree, clock, reset, 1'b1, ends_agree, "front and back disagree")
   `ASSERT_IMPLY(a_freed_was_used, clock, reset, 1'b1, free_top_seen, "freed node never handed out")
   `ASSERT_IMPLY(a_full_not_empty, clock, reset, free_empty, !list_empty, "full yet empty")
   `ASSERT_NEXT(a_accept_exam, clock, reset, accept, state_ff == S_EXAM, "item not examined")
   `ASSERT_NEXT(a_idle_on_load, clock, reset, req_stall && !load_rsp, req_stall, "lost a result")

endmodule
